@@ hw/rtl/ilir_pkg.sv @@
// Package for the indexed list block: request/result payload types,
// request and status codes, per-cell control struct and size defaults.
// No dependencies.
`default_nettype none

package ilir_pkg;

    localparam int DEPTH_DEFAULT = 64;

    localparam int TYPE_W   = 2;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 7;

    // Request codes
    localparam logic [TYPE_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_WRITE  = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_REMOVE = 2'd2;
    localparam logic [TYPE_W-1:0] REQ_NONE   = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [TYPE_W-1:0]        req_type;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] data_in;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] removed_value;
        logic [LEN_W-1:0]         length;
    } result_t;

    // Operation broadcast to every cell of the chain
    typedef struct packed {
        logic ins;   // open a gap at position, write data there
        logic wr;    // overwrite the entry at position
        logic rem;   // close the gap at position
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/ilir_cell.sv @@
// One list cell: holds a single entry and takes its neighbor's value
// on a shift. Depends on ilir_pkg.
`default_nettype none

module ilir_cell #(
    parameter int VW  = 7,
    parameter int IDX = 0
) (
    input  wire logic                              clk,
    input  wire ilir_pkg::cell_ctrl_t              ctrl,
    input  wire logic [VW-1:0]                     pos,
    input  wire logic signed [ilir_pkg::DATA_W-1:0] data,
    input  wire logic signed [ilir_pkg::DATA_W-1:0] left_value,
    input  wire logic signed [ilir_pkg::DATA_W-1:0] right_value,
    output logic signed [ilir_pkg::DATA_W-1:0]      value,
    output logic signed [ilir_pkg::DATA_W-1:0]      sel_value
);

    localparam logic [VW-1:0] MY_IDX = VW'(IDX);

    logic signed [ilir_pkg::DATA_W-1:0] value_reg;
    logic signed [ilir_pkg::DATA_W-1:0] value_next;
    logic                               at_pos;
    logic                               above_pos;

    assign at_pos    = (MY_IDX == pos);
    assign above_pos = (MY_IDX > pos);

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.ins && above_pos)
            value_next = left_value;
        else if ((ctrl.ins || ctrl.wr) && at_pos)
            value_next = data;
        else if (ctrl.rem && (above_pos || at_pos))
            value_next = right_value;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value     = value_reg;
    // Drive own entry onto the read bus only when addressed
    assign sel_value = at_pos ? value_reg : '0;

endmodule

`default_nettype wire

@@ hw/rtl/ilir_ctrl.sv @@
// Request decode for the list: checks position against the count, picks
// status, cell operation and next count. Depends on ilir_pkg.
`default_nettype none

module ilir_ctrl #(
    parameter int DEPTH = ilir_pkg::DEPTH_DEFAULT,
    parameter int CW    = 7,
    parameter int VW    = 7
) (
    input  wire logic [ilir_pkg::TYPE_W-1:0]    req_type,
    input  wire logic [VW-1:0]                  pos,
    input  wire logic [CW-1:0]                  count,
    output ilir_pkg::cell_ctrl_t                ctrl,
    output logic [ilir_pkg::STATUS_W-1:0]       status,
    output logic [CW-1:0]                       count_next
);

    logic [VW-1:0] cnt_ext;
    logic          full;

    assign cnt_ext = VW'(count);
    assign full    = (count == CW'(DEPTH));

    always_comb
    begin
        ctrl       = '0;
        status     = ilir_pkg::ST_OK;
        count_next = count;
        unique case (req_type)
            ilir_pkg::REQ_INSERT:
            begin
                if (pos > cnt_ext)
                    status = ilir_pkg::ST_RANGE;
                else if (full)
                    status = ilir_pkg::ST_FULL;
                else
                begin
                    ctrl.ins   = 1'b1;
                    count_next = count + CW'(1);
                end
            end
            ilir_pkg::REQ_WRITE:
            begin
                if (pos > cnt_ext)
                    status = ilir_pkg::ST_RANGE;
                else if (pos == cnt_ext)
                begin
                    if (full)
                        status = ilir_pkg::ST_FULL;
                    else
                    begin
                        ctrl.wr    = 1'b1;
                        count_next = count + CW'(1);
                    end
                end
                else
                    ctrl.wr = 1'b1;
            end
            ilir_pkg::REQ_REMOVE:
            begin
                if (count == '0)
                    status = ilir_pkg::ST_EMPTY;
                else if (pos >= cnt_ext)
                    status = ilir_pkg::ST_RANGE;
                else
                begin
                    ctrl.rem   = 1'b1;
                    count_next = count - CW'(1);
                end
            end
            ilir_pkg::REQ_NONE:
            begin
                status = ilir_pkg::ST_OK;
            end
            default:
            begin
                status = ilir_pkg::ST_OK;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/indexed_list_insert_remove_top.sv @@
// Top level of the positional list: a chain of DEPTH entry cells plus the
// request decoder and count register. Depends on ilir_pkg, ilir_cell, ilir_ctrl.
// A request taken at an edge shows its result, with done high,
// in the cycle right after. Throughput: one request per cycle; busy stays
// low, since every cell shifts in the same cycle. The receiver cannot stall.
// Reset clears the count and done; entry contents stay undefined until written.
`default_nettype none

module indexed_list_insert_remove_top #(
    parameter int DEPTH = ilir_pkg::DEPTH_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire ilir_pkg::request_t request,
    output logic                   done,
    output ilir_pkg::result_t      result
);

    // Count width holds DEPTH itself; compare width covers both position and count
    localparam int CW = $clog2(DEPTH + 1);
    localparam int VW = (CW > ilir_pkg::POS_W) ? CW : ilir_pkg::POS_W;

    logic [CW-1:0]                        count_reg;
    logic [CW-1:0]                        count_next;
    logic                                 done_reg;
    ilir_pkg::result_t                    result_reg;
    ilir_pkg::result_t                    result_next;

    logic                                 accept;
    logic [VW-1:0]                        pos_ext;
    ilir_pkg::cell_ctrl_t                 dec_ctrl;
    ilir_pkg::cell_ctrl_t                 cell_ctrl;
    logic [ilir_pkg::STATUS_W-1:0]        dec_status;
    logic [CW-1:0]                        dec_count;

    logic signed [ilir_pkg::DATA_W-1:0]   cell_value [DEPTH];
    logic signed [ilir_pkg::DATA_W-1:0]   cell_sel   [DEPTH];
    logic signed [ilir_pkg::DATA_W-1:0]   read_value;

    // Every request is taken at its accepting edge, so never hold off start
    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign pos_ext = VW'(request.position);

    ilir_ctrl #(
        .DEPTH (DEPTH),
        .CW    (CW),
        .VW    (VW)
    ) u_ctrl (
        .req_type   (request.req_type),
        .pos        (pos_ext),
        .count      (count_reg),
        .ctrl       (dec_ctrl),
        .status     (dec_status),
        .count_next (dec_count)
    );

    // Gate the cell operation so idle cycles hold every entry
    assign cell_ctrl = accept ? dec_ctrl : '0;

    // Chain of cells: on insert each cell above position takes its lower
    // neighbor, on remove each cell at or above position takes its upper one.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [ilir_pkg::DATA_W-1:0] left_v;
        logic signed [ilir_pkg::DATA_W-1:0] right_v;

        if (i == 0)
        begin : g_head
            assign left_v = request.data_in;
        end
        else
        begin : g_mid_l
            assign left_v = cell_value[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_v = cell_value[i];
        end
        else
        begin : g_mid_r
            assign right_v = cell_value[i+1];
        end

        ilir_cell #(
            .VW  (VW),
            .IDX (i)
        ) u_cell (
            .clk         (clk),
            .ctrl        (cell_ctrl),
            .pos         (pos_ext),
            .data        (request.data_in),
            .left_value  (left_v),
            .right_value (right_v),
            .value       (cell_value[i]),
            .sel_value   (cell_sel[i])
        );
    end

    // Only the addressed cell drives a nonzero value, so OR the bus together
    always_comb
    begin
        read_value = '0;
        for (int i = 0; i < DEPTH; i++)
            read_value = read_value | cell_sel[i];
    end

    always_comb
    begin
        count_next = accept ? dec_count : count_reg;

        result_next.status        = dec_status;
        result_next.removed_value = dec_ctrl.rem ? read_value : '0;
        result_next.length        = ilir_pkg::LEN_W'(dec_count);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    // Payload register: load on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Count never grows past the list capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("list count exceeds capacity");

    // A result follows every accepted request in the next cycle
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("done missing after accepted request");

    // A failed request reports no removed value
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ilir_pkg::ST_OK) |-> (result.removed_value == '0))
        else $error("removed value nonzero on failed request");

    // A rejected request leaves the count untouched
    a_fail_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && dec_status != ilir_pkg::ST_OK) |=> (count_reg == $past(count_reg)))
        else $error("count changed on rejected request");

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for indexed_list_insert_remove_top: checks insert, write,
// remove and ignored requests against a shadow list held in a small scoreboard class.
// Depends on ilir_pkg and the RTL of the list block.

module tb_top;
    import ilir_pkg::*;

    localparam int LIST_DEPTH   = DEPTH_DEFAULT;
    localparam int TOTAL_ITEMS  = 550;
    localparam int CYCLE_LIMIT  = 60000;
    localparam int DRAIN_LIMIT  = 200;

    // Shadow copy of the list: applies each accepted request, queues the
    // result it must produce and checks results in order of arrival.
    class list_shadow;
        logic [DATA_W-1:0] cells [LIST_DEPTH];
        int unsigned       held;
        result_t           pending_results [$];
        int unsigned       mismatches;
        int unsigned       checked;
        int unsigned       peak;
        int unsigned       status_tally [4];

        function new();
            held = 0;
            mismatches = 0;
            checked = 0;
            peak = 0;
            foreach (status_tally[i]) status_tally[i] = 0;
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction

        function void note_request(request_t rq);
            result_t     res;
            int unsigned pos;
            res.status        = ST_OK;
            res.removed_value = '0;
            pos               = rq.position;
            case (rq.req_type)
                REQ_INSERT:
                    if (pos > held)
                        res.status = ST_RANGE;
                    else if (held >= LIST_DEPTH)
                        res.status = ST_FULL;
                    else
                    begin
                        for (int i = held; i > pos; i--) cells[i] = cells[i-1];
                        cells[pos] = rq.data_in;
                        held++;
                    end
                REQ_WRITE:
                    if (pos > held)
                        res.status = ST_RANGE;
                    else if (pos == held)
                    begin
                        if (held >= LIST_DEPTH)
                            res.status = ST_FULL;
                        else
                        begin
                            cells[pos] = rq.data_in;
                            held++;
                        end
                    end
                    else
                        cells[pos] = rq.data_in;
                REQ_REMOVE:
                    if (held == 0)
                        res.status = ST_EMPTY;
                    else if (pos >= held)
                        res.status = ST_RANGE;
                    else
                    begin
                        res.removed_value = cells[pos];
                        for (int i = pos; i + 1 < held; i++) cells[i] = cells[i+1];
                        held--;
                    end
                default: ;
            endcase
            res.length = held[LEN_W-1:0];
            if (held > peak) peak = held;
            status_tally[res.status]++;
            pending_results.push_back(res);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with no request pending: status %0d removed %0d length %0d",
                         $time, got.status, got.removed_value, got.length);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (got.status !== want.status)
            begin
                $display("%0t: status: expected %0d, actual %0d",
                         $time, want.status, got.status);
                mismatches++;
            end
            if (got.removed_value !== want.removed_value)
            begin
                $display("%0t: removed_value: expected %0d, actual %0d",
                         $time, want.removed_value, got.removed_value);
                mismatches++;
            end
            if (got.length !== want.length)
            begin
                $display("%0t: length: expected %0d, actual %0d",
                         $time, want.length, got.length);
                mismatches++;
            end
        endfunction
    endclass

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    request_t request = '0;
    logic     busy;
    logic     done;
    result_t  result;

    list_shadow  shadow = new();
    int unsigned cycles = 0;
    int unsigned sent = 0;

    indexed_list_insert_remove_top #(
        .DEPTH (LIST_DEPTH)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Watch both handshakes at the edge: check the result first, so a result
    // never gets matched against the request taken at the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done) shadow.check_result(result);
            if (start && !busy) shadow.note_request(request);
        end
    end

    // Bail out if the block stops answering.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Plain random words half the time, else the signed extremes, zero or all ones.
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Keep most positions legal for the current length; aim the rest at the
    // edges and past the end so range errors keep showing up.
    function automatic logic [POS_W-1:0] pick_position(logic [TYPE_W-1:0] kind,
                                                       int unsigned held);
        int unsigned roll;
        int unsigned top;
        int unsigned low;
        roll = $urandom_range(0, 99);
        top  = (kind == REQ_REMOVE) ? ((held == 0) ? 0 : held - 1) : held;
        low  = (kind == REQ_REMOVE) ? held : held + 1;
        if (roll < 70)
            return POS_W'($urandom_range(0, top));
        if (roll < 82)
        begin
            case ($urandom_range(0, 2))
                0:       return '0;
                1:       return POS_W'(held);
                default: return POS_W'(LIST_DEPTH);
            endcase
        end
        if (low > LIST_DEPTH) return POS_W'(LIST_DEPTH);
        return POS_W'($urandom_range(low, LIST_DEPTH));
    endfunction

    // Request mix per traffic mode: 0 grows the list, 1 drains it, 2 is even.
    function automatic logic [TYPE_W-1:0] pick_kind(int unsigned mode);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 3) return REQ_NONE;
        case (mode)
            0:       return (roll < 55) ? REQ_INSERT : (roll < 88) ? REQ_WRITE : REQ_REMOVE;
            1:       return (roll < 15) ? REQ_INSERT : (roll < 25) ? REQ_WRITE : REQ_REMOVE;
            default: return (roll < 36) ? REQ_INSERT : (roll < 66) ? REQ_WRITE : REQ_REMOVE;
        endcase
    endfunction

    // Present one request and hold it until the block takes it. Called right
    // after a rising edge; returns right after the accepting edge.
    task automatic send_request(input logic [TYPE_W-1:0] kind,
                                input logic [POS_W-1:0]  pos,
                                input logic [DATA_W-1:0] value,
                                input bit                no_gap);
        int unsigned gap;
        gap = no_gap ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10));
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= '{req_type: kind, position: pos, data_in: value};
        // Sample busy mid-cycle, where it is settled.
        do @(negedge clk); while (busy);
        @(posedge clk);
        sent++;
    endtask

    // Drop start and stay quiet until every queued result has come back or DRAIN_LIMIT runs out.
    task automatic hold_until_drained();
        int unsigned waited;
        waited = 0;
        start <= 1'b0;
        do
        begin
            @(negedge clk);
            waited++;
        end
        while (shadow.outstanding() != 0 && waited < DRAIN_LIMIT);
        @(posedge clk);
    endtask

    initial
    begin
        int unsigned      mode;
        int unsigned      seg_len;
        bit               burst;
        logic [TYPE_W-1:0] kind;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-list and range errors, signed extremes, head/tail/
        // middle inserts, write over an entry, append, ignored code, removes.
        send_request(REQ_REMOVE, 0,  32'h1234_5678, 1'b0);
        send_request(REQ_REMOVE, 64, 32'h0,         1'b0);
        send_request(REQ_INSERT, 1,  32'h1,         1'b0);
        send_request(REQ_WRITE,  1,  32'h2,         1'b0);
        send_request(REQ_INSERT, 0,  32'h7FFF_FFFF, 1'b1);
        send_request(REQ_INSERT, 0,  32'h8000_0000, 1'b1);
        send_request(REQ_WRITE,  2,  32'hFFFF_FFFF, 1'b0);
        send_request(REQ_INSERT, 1,  32'h0,         1'b0);
        send_request(REQ_WRITE,  0,  32'h5555_5555, 1'b1);
        send_request(REQ_INSERT, 4,  32'hAAAA_AAAA, 1'b0);
        send_request(REQ_INSERT, 6,  32'h3,         1'b0);
        send_request(REQ_WRITE,  64, 32'h4,         1'b0);
        send_request(REQ_NONE,   64, 32'hFFFF_FFFF, 1'b0);
        send_request(REQ_NONE,   0,  32'h0,         1'b1);
        send_request(REQ_REMOVE, 5,  32'h0,         1'b0);
        send_request(REQ_REMOVE, 64, 32'h0,         1'b0);
        send_request(REQ_REMOVE, 4,  32'h0,         1'b1);
        send_request(REQ_REMOVE, 0,  32'h0,         1'b1);
        send_request(REQ_REMOVE, 1,  32'h0,         1'b0);
        send_request(REQ_REMOVE, 0,  32'hFFFF_FFFF, 1'b0);
        hold_until_drained();

        // Random: open with a long growth stretch so the list fills up and
        // full-list requests get hit, then mixed stretches of each mode.
        mode    = 0;
        seg_len = 110;
        burst   = 1'b0;
        while (sent < TOTAL_ITEMS)
        begin
            for (int n = 0; n < seg_len && sent < TOTAL_ITEMS; n++)
            begin
                kind = pick_kind(mode);
                send_request(kind, pick_position(kind, shadow.held), pick_value(), burst);
            end
            // Pause once in the middle of the run with everything flushed.
            if (sent >= TOTAL_ITEMS / 2 && sent < TOTAL_ITEMS / 2 + seg_len + 1)
                hold_until_drained();
            mode    = $urandom_range(0, 2);
            seg_len = $urandom_range(20, 80);
            burst   = ($urandom_range(0, 3) == 0);
        end

        hold_until_drained();
        repeat (4) @(posedge clk);
        if (shadow.outstanding() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, shadow.outstanding());
            shadow.mismatches++;
        end

        $display("Sent %0d requests: %0d ok, %0d out of range, %0d on empty, %0d on full.",
                 sent, shadow.status_tally[ST_OK], shadow.status_tally[ST_RANGE],
                 shadow.status_tally[ST_EMPTY], shadow.status_tally[ST_FULL]);
        $display("Checked %0d results; the list peaked at %0d entries.",
                 shadow.checked, shadow.peak);
        if (shadow.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/ilir_pkg.sv
hw/rtl/ilir_cell.sv
hw/rtl/ilir_ctrl.sv
hw/rtl/indexed_list_insert_remove_top.sv
verif/tb_top.sv
